// ===== sv/utf8_stream_decoder_core_assert.svh =====
// Assertion macros for the UTF-8 stream decoder.
// Used by the RTL files in this folder; expects clk and rst_n in scope.
`ifndef UTF8_STREAM_DECODER_CORE_ASSERT_SVH
`define UTF8_STREAM_DECODER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Property checked on every clock edge once reset is released.
`define UTF8SD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("utf8sd assertion failed");
// Property checked on every clock edge, reset included.
`define UTF8SD_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("utf8sd assertion failed");
`else
`define UTF8SD_ASSERT(lbl, prop)
`define UTF8SD_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// ===== sv/utf8sd_pkg.sv =====
// Shared types and constants for the UTF-8 stream decoder.
// No dependencies.
package utf8sd_pkg;

  localparam int BYTE_W  = 8;
  localparam int CP_W    = 21;
  localparam int BUF_N   = 4;   // pending bytes plus the new one
  localparam int AVAIL_W = 3;   // holds 0..BUF_N

  localparam logic [CP_W-1:0] REPL_CHAR = 21'h00FFFD;
  localparam logic [CP_W-1:0] MAX_CP    = 21'h10FFFF;

  typedef logic [BYTE_W-1:0] byte_t;

  // Verdict of the decode unit on the sequence at the buffer head
  typedef struct packed {
    logic              stop;      // sequence undecided, keep bytes pending
    logic [CP_W-1:0]   code_point;
    logic              replaced;
    logic [AVAIL_W-1:0] consume;  // bytes used by this result (1..4)
  } dec_res_t;

endpackage

// ===== sv/utf8sd_decode.sv =====
// Decode unit: judges the UTF-8 sequence at the head of the byte buffer.
// Depends on utf8sd_pkg.
module utf8sd_decode (
  input  utf8sd_pkg::byte_t                 buf0,
  input  utf8sd_pkg::byte_t                 buf1,
  input  utf8sd_pkg::byte_t                 buf2,
  input  utf8sd_pkg::byte_t                 buf3,
  input  logic [utf8sd_pkg::AVAIL_W-1:0]    avail,
  input  logic                              eos,
  output utf8sd_pkg::dec_res_t              res
);

  logic [utf8sd_pkg::AVAIL_W-1:0] len;
  logic [utf8sd_pkg::CP_W-1:0]    scalar;
  logic                           cont_ok;
  logic                           second_ok;
  logic                           c1, c2, c3;

  // Sequence length from the lead byte
  always_comb begin
    if (buf0 >= 8'hC2 && buf0 <= 8'hDF) begin
      len = 3'd2;
    end else if (buf0 >= 8'hE0 && buf0 <= 8'hEF) begin
      len = 3'd3;
    end else if (buf0 >= 8'hF0 && buf0 <= 8'hF4) begin
      len = 3'd4;
    end else begin
      len = 3'd1;
    end
  end

  assign c1 = (buf1[7:6] == 2'b10);
  assign c2 = (buf2[7:6] == 2'b10);
  assign c3 = (buf3[7:6] == 2'b10);

  // Scalar assembly and continuation checks
  always_comb begin
    case (len)
      3'd2: begin
        scalar  = {10'd0, buf0[4:0], buf1[5:0]};
        cont_ok = c1;
      end
      3'd3: begin
        scalar  = {5'd0, buf0[3:0], buf1[5:0], buf2[5:0]};
        cont_ok = c1 && c2;
      end
      3'd4: begin
        scalar  = {buf0[2:0], buf1[5:0], buf2[5:0], buf3[5:0]};
        cont_ok = c1 && c2 && c3;
      end
      default: begin
        scalar  = {13'd0, buf0};
        cont_ok = 1'b1;
      end
    endcase
  end

  // Overlong, surrogate and above-range forms, judged on the second byte
  assign second_ok = !((buf0 == 8'hE0 && buf1 < 8'hA0) ||
                       (buf0 == 8'hED && buf1 >= 8'hA0) ||
                       (buf0 == 8'hF0 && buf1 < 8'h90) ||
                       (buf0 == 8'hF4 && buf1 >= 8'h90));

  // Verdict
  always_comb begin
    res.stop       = 1'b0;
    res.code_point = utf8sd_pkg::REPL_CHAR;
    res.replaced   = 1'b1;
    res.consume    = 3'd1;
    if (len == 3'd1) begin
      // single byte: ASCII passes, anything else is a stray byte
      if (!buf0[7]) begin
        res.code_point = scalar;
        res.replaced   = 1'b0;
      end
    end else if (len > avail) begin
      // cut short: wait for more bytes unless the string ends here
      res.stop = !eos;
    end else if (cont_ok && second_ok && scalar <= utf8sd_pkg::MAX_CP) begin
      res.code_point = scalar;
      res.replaced   = 1'b0;
      res.consume    = len;
    end
  end

endmodule

// ===== sv/utf8_stream_decoder_core.sv =====
// UTF-8 stream decoder: takes one byte per item (with an end-of-string flag) and
// gives Unicode code points, U+FFFD with out_replaced set for each bad lead or
// stray byte. A single decode unit judges one sequence per cycle unless out_ready
// stalls, and the sequencer shifts the 4-byte buffer by what it consumed; the next
// byte is taken only once the last one's results are out or its bytes are left pending.
// in_ready is high only between items. Depends on utf8sd_pkg, utf8sd_decode.
`include "utf8_stream_decoder_core_assert.svh"
module utf8_stream_decoder_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [utf8sd_pkg::BYTE_W-1:0] in_data_byte,
  input  logic                          in_end_of_string,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [utf8sd_pkg::CP_W-1:0]   out_code_point,
  output logic                          out_replaced,
  output logic                          out_last_of_string
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic                            state_r, state_nxt;
  utf8sd_pkg::byte_t               buf_r   [utf8sd_pkg::BUF_N];
  utf8sd_pkg::byte_t               buf_nxt [utf8sd_pkg::BUF_N];
  logic [utf8sd_pkg::AVAIL_W-1:0]  avail_r, avail_nxt;
  logic                            eos_r, eos_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [utf8sd_pkg::CP_W-1:0]     out_cp_r, out_cp_nxt;
  logic                            out_rep_r, out_rep_nxt;
  logic                            out_last_r, out_last_nxt;

  utf8sd_pkg::dec_res_t            dec;
  logic [utf8sd_pkg::AVAIL_W-1:0]  remain;
  logic                            slot_free;
  logic                            in_fire;

  utf8sd_decode u_decode (
    .buf0  (buf_r[0]),
    .buf1  (buf_r[1]),
    .buf2  (buf_r[2]),
    .buf3  (buf_r[3]),
    .avail (avail_r),
    .eos   (eos_r),
    .res   (dec)
  );

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign remain    = avail_r - dec.consume;

  // Sequencer: load the new byte behind the pending ones, then decode one sequence
  // per cycle while the result slot is free, shifting the buffer down by what was consumed
  always_comb begin
    state_nxt     = state_r;
    avail_nxt     = avail_r;
    eos_nxt       = eos_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_cp_nxt    = out_cp_r;
    out_rep_nxt   = out_rep_r;
    out_last_nxt  = out_last_r;
    for (int i = 0; i < utf8sd_pkg::BUF_N; i++) begin
      buf_nxt[i] = buf_r[i];
    end
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          buf_nxt[avail_r[1:0]] = in_data_byte;
          avail_nxt             = avail_r + 3'd1;
          eos_nxt               = in_end_of_string;
          state_nxt             = ST_RUN;
        end
      end
      ST_RUN: begin
        if (slot_free) begin
          if (dec.stop) begin
            state_nxt = ST_IDLE;
          end else begin
            out_valid_nxt = 1'b1;
            out_cp_nxt    = dec.code_point;
            out_rep_nxt   = dec.replaced;
            out_last_nxt  = eos_r && (remain == '0);
            avail_nxt     = remain;
            if (remain == '0) begin
              state_nxt = ST_IDLE;
            end
            case (dec.consume)
              3'd1: begin
                buf_nxt[0] = buf_r[1];
                buf_nxt[1] = buf_r[2];
                buf_nxt[2] = buf_r[3];
              end
              3'd2: begin
                buf_nxt[0] = buf_r[2];
                buf_nxt[1] = buf_r[3];
              end
              3'd3: begin
                buf_nxt[0] = buf_r[3];
              end
              default: begin
                // whole buffer used, contents no longer read
              end
            endcase
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      avail_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      avail_r     <= avail_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    eos_r      <= eos_nxt;
    out_cp_r   <= out_cp_nxt;
    out_rep_r  <= out_rep_nxt;
    out_last_r <= out_last_nxt;
    for (int i = 0; i < utf8sd_pkg::BUF_N; i++) begin
      buf_r[i] <= buf_nxt[i];
    end
  end

  assign out_valid          = out_valid_r;
  assign out_code_point     = out_cp_r;
  assign out_replaced       = out_rep_r;
  assign out_last_of_string = out_last_r;

  // Between items at most three bytes stay pending
  `UTF8SD_ASSERT(a_pending_max, (state_r == ST_IDLE) |-> (avail_r <= 3'd3))
  // While decoding the buffer is never empty
  `UTF8SD_ASSERT(a_run_nonempty, (state_r == ST_RUN) |-> (avail_r != '0 && avail_r <= 3'd4))
  // A sequence is only left undecided when the string goes on
  `UTF8SD_ASSERT(a_stop_no_eos, (state_r == ST_RUN && dec.stop) |-> !eos_r)
  // Once the last result of a string is shown, nothing stays pending
  `UTF8SD_ASSERT(a_last_flush,
    (state_r == ST_IDLE && out_valid_r && out_last_r) |-> (avail_r == '0))
  // Reset leaves the block ready with nothing to show
  `UTF8SD_ASSERT_ALWAYS(a_reset_clear, !rst_n |=> (!out_valid_r && state_r == ST_IDLE))

endmodule

// ===== test/utf8_stream_decoder_core_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the UTF-8 stream decoder: decodes every accepted byte on its own
// and checks the code point channel in order. Depends on utf8sd_pkg.
module utf8_stream_decoder_core_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic [utf8sd_pkg::BYTE_W-1:0] in_data_byte,
  input  logic                          in_end_of_string,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [utf8sd_pkg::CP_W-1:0]   out_code_point,
  input  logic                          out_replaced,
  input  logic                          out_last_of_string,
  output int                            fail_count,
  output int                            outstanding
);

  localparam int CP_W = utf8sd_pkg::CP_W;

  typedef struct packed {
    logic [CP_W-1:0] code_point;
    logic            replaced;
    logic            last_of_string;
  } code_point_t;

  code_point_t       expected_cps[$];
  utf8sd_pkg::byte_t held_bytes[3];
  int                held_count = 0;
  int                mismatches = 0;

  // Sequence length announced by a lead byte; 1 for ASCII and bad bytes
  function automatic int lead_length(utf8sd_pkg::byte_t lead);
    if (lead >= 8'hC2 && lead <= 8'hDF) return 2;
    if (lead >= 8'hE0 && lead <= 8'hEF) return 3;
    if (lead >= 8'hF0 && lead <= 8'hF4) return 4;
    return 1;
  endfunction

  // Decode held bytes plus one new byte; queue the code points this item settles
  task automatic decode_byte(input utf8sd_pkg::byte_t value, input logic eos);
    utf8sd_pkg::byte_t win[4];
    code_point_t       found[4];
    int                total;
    int                pos;
    int                len;
    int                n;
    int                k;
    logic              waiting;
    logic              ok;
    logic [CP_W-1:0]   scalar;
    total   = 0;
    pos     = 0;
    n       = 0;
    waiting = 1'b0;
    for (k = 0; k < held_count; k++) begin
      win[total] = held_bytes[k];
      total++;
    end
    win[total] = value;
    total++;

    while (pos < total && !waiting) begin
      len = lead_length(win[pos]);
      if (len == 1) begin
        // ASCII passes through, anything else alone is a stray byte
        if (win[pos] < 8'h80) found[n] = '{CP_W'(win[pos]), 1'b0, 1'b0};
        else found[n] = '{utf8sd_pkg::REPL_CHAR, 1'b1, 1'b0};
        n++;
        pos++;
      end else if (pos + len > total) begin
        // not enough bytes yet: hold them, unless the string ends here
        if (!eos) begin
          waiting = 1'b1;
        end else begin
          found[n] = '{utf8sd_pkg::REPL_CHAR, 1'b1, 1'b0};
          n++;
          pos++;
        end
      end else begin
        scalar = CP_W'(win[pos]) & CP_W'((1 << (7 - len)) - 1);
        ok = 1'b1;
        for (k = 1; k < len; k++) begin
          if (win[pos+k][7:6] != 2'b10) ok = 1'b0;
          scalar = {scalar[CP_W-7:0], win[pos+k][5:0]};
        end
        // overlong, surrogate and above-range forms
        if (win[pos] == 8'hE0 && win[pos+1] < 8'hA0) ok = 1'b0;
        if (win[pos] == 8'hED && win[pos+1] >= 8'hA0) ok = 1'b0;
        if (win[pos] == 8'hF0 && win[pos+1] < 8'h90) ok = 1'b0;
        if (win[pos] == 8'hF4 && win[pos+1] >= 8'h90) ok = 1'b0;
        if (ok && scalar <= utf8sd_pkg::MAX_CP) begin
          found[n] = '{scalar, 1'b0, 1'b0};
          pos += len;
        end else begin
          // only the lead is replaced, the rest gets parsed again
          found[n] = '{utf8sd_pkg::REPL_CHAR, 1'b1, 1'b0};
          pos++;
        end
        n++;
      end
    end

    held_count = 0;
    while (pos < total && held_count < 3) begin
      held_bytes[held_count] = win[pos];
      held_count++;
      pos++;
    end

    if (eos && n > 0) found[n-1].last_of_string = 1'b1;
    for (k = 0; k < n; k++) expected_cps = {expected_cps, found[k]};
  endtask

  always @(posedge clk) begin : scoreboard
    code_point_t want;
    if (!rst_n) begin
      expected_cps.delete();
      held_count = 0;
    end else begin
      // results first: a result at this edge cannot stem from a byte taken at it
      if (out_valid && out_ready) begin
        if (expected_cps.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected code point %h rep %b last %b", $realtime,
                     out_code_point, out_replaced, out_last_of_string);
        end else begin
          want = expected_cps.pop_front();
          if (out_code_point !== want.code_point || out_replaced !== want.replaced ||
              out_last_of_string !== want.last_of_string) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: expected cp %h rep %b last %b, got cp %h rep %b last %b",
                       $realtime, want.code_point, want.replaced, want.last_of_string,
                       out_code_point, out_replaced, out_last_of_string);
          end
        end
      end
      if (in_valid && in_ready) decode_byte(in_data_byte, in_end_of_string);
    end
    fail_count  <= mismatches;
    outstanding <= expected_cps.size();
  end

endmodule

// ===== test/utf8_stream_decoder_core_tb.sv =====
`timescale 1ns / 1ps
// Top of the UTF-8 stream decoder test: drives byte strings with random gaps and
// stalls, gives the verdict. Depends on utf8sd_pkg, utf8_stream_decoder_core and the checker module.
module utf8_stream_decoder_core_tb;

  logic                          clk = 1'b0;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_ready;
  logic [utf8sd_pkg::BYTE_W-1:0] in_data_byte;
  logic                          in_end_of_string;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [utf8sd_pkg::CP_W-1:0]   out_code_point;
  logic                          out_replaced;
  logic                          out_last_of_string;
  int                            fail_count;
  int                            outstanding;

  logic                          gaps_on = 1'b1;
  utf8sd_pkg::byte_t             text_bytes[$];
  int                            random_sent = 0;

  // {end_of_string, byte}
  logic [8:0] directed_items[$] = '{
    9'h000,                          // NUL
    9'h0C2, 9'h080,                  // lowest two-byte
    9'h0F4, 9'h08F, 9'h0BF, 9'h1BF,  // highest scalar, end of string
    9'h080, 9'h0C0, 9'h0FF,          // stray bytes
    9'h0E0, 9'h09F, 9'h080,          // overlong three-byte
    9'h0ED, 9'h0A0, 9'h080,          // surrogate
    9'h0F0, 9'h08F, 9'h080, 9'h080,  // overlong four-byte
    9'h0F4, 9'h090, 9'h080, 9'h180,  // above U+10FFFF
    9'h0C2, 9'h17F,                  // bad continuation
    9'h0E2, 9'h182                   // cut short by end of string
  };

  utf8_stream_decoder_core dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_data_byte       (in_data_byte),
    .in_end_of_string   (in_end_of_string),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_code_point     (out_code_point),
    .out_replaced       (out_replaced),
    .out_last_of_string (out_last_of_string)
  );

  utf8_stream_decoder_core_checker cp_check (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_data_byte       (in_data_byte),
    .in_end_of_string   (in_end_of_string),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_code_point     (out_code_point),
    .out_replaced       (out_replaced),
    .out_last_of_string (out_last_of_string),
    .fail_count         (fail_count),
    .outstanding        (outstanding)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Result side stalls about a quarter of the time while gaps are on
  always @(posedge clk) begin
    out_ready <= !gaps_on || ($urandom_range(0, 99) >= 26);
  end

  // Offer one byte, with an optional random gap before it, and wait for the take
  task automatic send_item(input utf8sd_pkg::byte_t value, input logic eos);
    while (gaps_on && $urandom_range(0, 99) < 26) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_data_byte     <= value;
    in_end_of_string <= eos;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Append one byte to the string being built
  task automatic add_byte(input utf8sd_pkg::byte_t value);
    text_bytes = {text_bytes, value};
  endtask

  // Append one character: mostly well-formed, sometimes a bad or cut sequence
  task automatic push_char();
    int unsigned kind;
    int unsigned cp;
    logic [7:0]  lead;
    logic [7:0]  second;
    kind = $urandom_range(0, 99);
    if (kind < 30) begin
      add_byte(8'($urandom_range(0, 'h7F)));
    end else if (kind < 48) begin
      cp = $urandom_range('h80, 'h7FF);
      add_byte(8'hC0 | 8'(cp >> 6));
      add_byte(8'h80 | 8'(cp & 'h3F));
    end else if (kind < 64) begin
      cp = $urandom_range('h800, 'hFFFF);
      if (cp >= 'hD800 && cp <= 'hDFFF) cp ^= 'h1000;
      add_byte(8'hE0 | 8'(cp >> 12));
      add_byte(8'h80 | 8'((cp >> 6) & 'h3F));
      add_byte(8'h80 | 8'(cp & 'h3F));
    end else if (kind < 76) begin
      cp = $urandom_range('h10000, 'h10FFFF);
      add_byte(8'hF0 | 8'(cp >> 18));
      add_byte(8'h80 | 8'((cp >> 12) & 'h3F));
      add_byte(8'h80 | 8'((cp >> 6) & 'h3F));
      add_byte(8'h80 | 8'(cp & 'h3F));
    end else if (kind < 84) begin
      // lead whose second byte falls outside its allowed range
      case ($urandom_range(0, 3))
        0: begin lead = 8'hE0; second = 8'($urandom_range('h80, 'h9F)); end
        1: begin lead = 8'hED; second = 8'($urandom_range('hA0, 'hBF)); end
        2: begin lead = 8'hF0; second = 8'($urandom_range('h80, 'h8F)); end
        default: begin lead = 8'hF4; second = 8'($urandom_range('h90, 'hBF)); end
      endcase
      add_byte(lead);
      add_byte(second);
      add_byte(8'($urandom_range('h80, 'hBF)));
      if (lead >= 8'hF0) add_byte(8'($urandom_range('h80, 'hBF)));
    end else if (kind < 92) begin
      // lead missing its tail
      lead = 8'($urandom_range('hC2, 'hF4));
      add_byte(lead);
      if (lead >= 8'hE0) add_byte(8'($urandom_range('h80, 'hBF)));
    end else begin
      add_byte(8'($urandom_range(0, 255)));
    end
  endtask

  // Build one string, maybe corrupt a byte, and send it
  task automatic send_string();
    int chars;
    int k;
    logic close_it;
    text_bytes.delete();
    chars = $urandom_range(1, 6);
    for (k = 0; k < chars; k++) push_char();
    if ($urandom_range(0, 9) == 0)
      text_bytes[$urandom_range(0, text_bytes.size() - 1)] = 8'($urandom_range(0, 255));
    close_it = ($urandom_range(0, 99) < 80);
    for (k = 0; k < text_bytes.size(); k++) begin
      gaps_on = !(random_sent >= 120 && random_sent < 200);
      send_item(text_bytes[k], close_it && (k == text_bytes.size() - 1));
      random_sent++;
    end
  endtask

  initial begin
    rst_n            <= 1'b0;
    in_valid         <= 1'b0;
    in_data_byte     <= '0;
    in_end_of_string <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_items[i]) send_item(directed_items[i][7:0], directed_items[i][8]);
    while (random_sent < 300) send_string();
    in_valid <= 1'b0;
    gaps_on = 1'b1;

    // let the last expectations register, then drain
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Run limit
  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
